// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/ida_pkg.sv
// Types and fixed field widths of the id allocator.
// No dependencies; imported by the interfaces and the top level.
package ida_pkg;

	localparam int ID_BITS  = 8;
	localparam int HANDLE_W = 32;

	typedef enum logic [1:0] {
		OP_REG    = 2'd0,
		OP_FREE   = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_LIVE = 2'd2,
		ST_BAD_FREE = 2'd3
	} status_t;

endpackage

// File: hw/rtl/ida_if.sv
// Valid/ready channel interfaces for requests and responses of the id allocator.
// Depends on ida_pkg.
interface ida_req_if import ida_pkg::*; ();
	logic                valid;
	logic                ready;
	op_t                 op;
	logic [ID_BITS-1:0]  ident;
	logic [HANDLE_W-1:0] handle_in;

	modport source (output valid, output op, output ident, output handle_in, input ready);
	modport sink (input valid, input op, input ident, input handle_in, output ready);
endinterface

interface ida_rsp_if import ida_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ID_BITS-1:0]  assigned_id;
	logic [HANDLE_W-1:0] handle_out;
	status_t             status;

	modport source (output valid, output assigned_id, output handle_out, output status,
		input ready);
	modport sink (input valid, input assigned_id, input handle_out, input status,
		output ready);
endinterface

// File: hw/rtl/ida_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies; used for the free queue and the handle table.
module ida_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/id_allocator_with_handle_table.sv
// Id allocator with a first-in first-out free list and a handle table, in two RAMs.
// An accepted request waits in stage 1 for its RAM reads; its result then goes into the output
// register until the response transfers; stage 1 stalls while that register is full.
// A new request is taken only once stage 1 has finished the last one, with its write-back.
// Reset: control state clears at once, no clearing pass; the initial free list and the
// never-allocated table entries are implied by the head pointer. Depends on ida_pkg, ida_if.
`include "assert_macros.svh"

module id_allocator_with_handle_table import ida_pkg::*; #(
	parameter int MAX_IDS     = 256,
	parameter int HANDLE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ida_req_if.sink    req,
	ida_rsp_if.source  rsp
);

	// Internal id width, live count width, stored handle width and the width used to
	// compare an incoming id against the id range.
	localparam int IDW = $clog2(MAX_IDS);
	localparam int CW  = IDW + 1;
	localparam int SW  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int EW  = SW + 1;
	localparam int XW  = ((IDW > ID_BITS) ? IDW : ID_BITS) + 1;

	localparam logic [IDW-1:0] LAST_ID  = IDW'(MAX_IDS - 1);
	localparam logic [CW-1:0]  FULL_CNT = CW'(MAX_IDS);
	localparam logic [XW-1:0]  ID_LIMIT = XW'(MAX_IDS);

	// Free list pointers. While the head has not yet wrapped it is still on its first
	// pass, where the id it pops is its own position rather than a queue read, and
	// the ids below the head are exactly those that have ever been allocated.
	logic [IDW-1:0] head_q;
	logic [IDW-1:0] tail_q;
	logic           head_wrap_q;
	logic [CW-1:0]  live_cnt_q;

	// Stage 1: the request whose RAM reads are in flight.
	logic                s1_valid_q;
	op_t                 op_s1;
	logic [ID_BITS-1:0]  ident_s1;
	logic [SW-1:0]       handle_s1;

	// Output register.
	logic                rsp_valid_q;
	logic [ID_BITS-1:0]  assigned_q;
	logic [HANDLE_W-1:0] handle_out_q;
	status_t             status_q;

	logic                accept;
	logic                done;
	logic [XW-1:0]       req_ident_x;
	logic [XW-1:0]       s1_ident_x;
	logic [IDW-1:0]      s1_addr;
	logic                s1_live;
	logic                full;
	logic [IDW-1:0]      pop_id;
	logic                do_reg;
	logic                do_free;

	logic [IDW-1:0]      q_rdata;
	logic [EW-1:0]       tbl_rdata;
	logic                tbl_we;
	logic [IDW-1:0]      tbl_waddr;
	logic [EW-1:0]       tbl_wdata;

	logic [ID_BITS-1:0]  res_assigned;
	logic [HANDLE_W-1:0] res_handle;
	status_t             res_status;

	logic                s1_stall;
	logic                rsp_full;
	logic                s1_free;

	// A new request is taken only once stage 1 is empty. Reads are issued only at a
	// transfer and writes only when stage 1 completes, so a read never meets a write
	// to the same entry and read data stays put while stage 1 is stalled.
	assign accept    = req.valid && req.ready;
	assign req.ready = !s1_valid_q;
	assign done      = s1_valid_q && (!rsp_valid_q || rsp.ready);

	assign req_ident_x = XW'(req.ident);
	assign s1_ident_x  = XW'(ident_s1);
	assign s1_addr     = s1_ident_x[IDW-1:0];

	// Each table entry holds a live bit above the stored handle.
	ida_ram #(
		.DEPTH (MAX_IDS),
		.WIDTH (IDW)
	) u_free_queue (
		.clk   (clk),
		.we    (do_free),
		.waddr (tail_q),
		.wdata (s1_addr),
		.re    (accept),
		.raddr (head_q),
		.rdata (q_rdata)
	);

	ida_ram #(
		.DEPTH (MAX_IDS),
		.WIDTH (EW)
	) u_handle_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (accept),
		.raddr (req_ident_x[IDW-1:0]),
		.rdata (tbl_rdata)
	);

	// An id is live only if it is in range, has been allocated at least once (so its
	// table entry has been written) and its stored live bit is set.
	assign s1_live = (s1_ident_x < ID_LIMIT) && (head_wrap_q || (s1_addr < head_q))
		&& tbl_rdata[SW];
	assign full    = (live_cnt_q == FULL_CNT);
	assign pop_id  = head_wrap_q ? q_rdata : head_q;
	assign do_reg  = done && (op_s1 == OP_REG) && !full;
	assign do_free = done && (op_s1 == OP_FREE) && s1_live;

	// A register writes the handle under the popped id; a free clears the live bit.
	assign tbl_we    = do_reg || do_free;
	assign tbl_waddr = do_reg ? pop_id : s1_addr;
	assign tbl_wdata = do_reg ? {1'b1, handle_s1} : {1'b0, {SW{1'b0}}};

	always_comb begin
		res_assigned = '0;
		res_handle   = '0;
		res_status   = ST_OK;
		case (op_s1)
			OP_REG: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					res_assigned = ID_BITS'(pop_id);
				end
			end
			OP_FREE: begin
				if (!s1_live) begin
					res_status = ST_BAD_FREE;
				end
			end
			OP_LOOKUP: begin
				if (s1_live) begin
					res_handle = HANDLE_W'(tbl_rdata[SW-1:0]);
				end else begin
					res_status = ST_NOT_LIVE;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= req.op;
			ident_s1  <= req.ident;
			handle_s1 <= SW'(req.handle_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			head_wrap_q <= 1'b0;
			live_cnt_q  <= '0;
		end else begin
			if (do_reg) begin
				live_cnt_q <= live_cnt_q + 1'b1;
				if (head_q == LAST_ID) begin
					head_q      <= '0;
					head_wrap_q <= 1'b1;
				end else begin
					head_q <= head_q + 1'b1;
				end
			end
			if (do_free) begin
				live_cnt_q <= live_cnt_q - 1'b1;
				if (tail_q == LAST_ID) begin
					tail_q <= '0;
				end else begin
					tail_q <= tail_q + 1'b1;
				end
			end
		end
	end

	// The output register frees stage 1 as soon as it has room, so a new request can be
	// taken while a finished response still waits for its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			assigned_q   <= res_assigned;
			handle_out_q <= res_handle;
			status_q     <= res_status;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.assigned_id = assigned_q;
	assign rsp.handle_out  = handle_out_q;
	assign rsp.status      = status_q;

	// Conditions watched by the checks below.
	assign s1_stall = s1_valid_q && rsp_valid_q && !rsp.ready;
	assign rsp_full = rsp_valid_q && (status_q == ST_FULL);
	assign s1_free  = s1_valid_q && (op_s1 == OP_FREE);

	// The live count can never pass the number of ids.
	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, live_cnt_q <= FULL_CNT)
	// A stalled stage 1 keeps its request.
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_stall, s1_valid_q && $stable(op_s1) && $stable(ident_s1))
	// A full report stands only while every id is live.
	`ASSERT_IMPLIES(a_full_cnt, clk, arst_n, rsp_full, full)
	// With no live id, no free can succeed.
	`ASSERT_IMPLIES(a_free_none, clk, arst_n, s1_free && (live_cnt_q == '0), !s1_live)

endmodule
